// ----- rtl/sitp_pkg.sv -----
// Package for the signed integer text parser: character codes, character classes
// and the queue item type that the front and back parts share.
// No dependencies.
package sitp_pkg;

   localparam int CHAR_BITS        = 8;
   localparam int VALUE_BITS       = 32;
   localparam int DIGIT_BITS       = 4;
   localparam int CLASS_BITS       = 3;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = 1;
   localparam int QUEUE_COUNT_BITS = 2;

   localparam logic [CHAR_BITS-1:0] CH_TAB      = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_CR       = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE    = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS     = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS    = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO     = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE     = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A  = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_F  = 8'h46;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A  = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_F  = 8'h66;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_X  = 8'h78;

   localparam logic [DIGIT_BITS-1:0] HEX_LETTER_OFFSET = 4'd9;

   localparam logic [CLASS_BITS-1:0] CLS_OTHER = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLS_BLANK = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLS_MINUS = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLS_PLUS  = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLS_ZERO  = 3'd4;
   localparam logic [CLASS_BITS-1:0] CLS_DEC   = 3'd5;
   localparam logic [CLASS_BITS-1:0] CLS_LOWX  = 3'd6;
   localparam logic [CLASS_BITS-1:0] CLS_HEXL  = 3'd7;

   typedef struct packed {
      logic                  start;
      logic [CLASS_BITS-1:0] cls;
      logic [DIGIT_BITS-1:0] digit;
   } item_type;

endpackage

// ----- rtl/sitp_front.sv -----
// Front part of the signed integer text parser: takes characters and classifies them.
// Depends on sitp_pkg.
module sitp_front (
   input  logic [sitp_pkg::CHAR_BITS-1:0] ch,
   input  logic                           start,
   output sitp_pkg::item_type             item
);

   logic [sitp_pkg::CLASS_BITS-1:0] cls;
   logic [sitp_pkg::DIGIT_BITS-1:0] digit;

   always_comb begin
      cls   = sitp_pkg::CLS_OTHER;
      digit = ch[sitp_pkg::DIGIT_BITS-1:0];
      priority if (ch == sitp_pkg::CH_SPACE ||
                   (ch >= sitp_pkg::CH_TAB && ch <= sitp_pkg::CH_CR)) begin
         cls = sitp_pkg::CLS_BLANK;
      end else if (ch == sitp_pkg::CH_MINUS) begin
         cls = sitp_pkg::CLS_MINUS;
      end else if (ch == sitp_pkg::CH_PLUS) begin
         cls = sitp_pkg::CLS_PLUS;
      end else if (ch == sitp_pkg::CH_ZERO) begin
         cls = sitp_pkg::CLS_ZERO;
      end else if (ch > sitp_pkg::CH_ZERO && ch <= sitp_pkg::CH_NINE) begin
         cls = sitp_pkg::CLS_DEC;
      end else if (ch == sitp_pkg::CH_LOWER_X) begin
         cls = sitp_pkg::CLS_LOWX;
      end else if ((ch >= sitp_pkg::CH_LOWER_A && ch <= sitp_pkg::CH_LOWER_F) ||
                   (ch >= sitp_pkg::CH_UPPER_A && ch <= sitp_pkg::CH_UPPER_F)) begin
         cls   = sitp_pkg::CLS_HEXL;
         digit = ch[sitp_pkg::DIGIT_BITS-1:0] + sitp_pkg::HEX_LETTER_OFFSET;
      end else begin
         cls = sitp_pkg::CLS_OTHER;
      end
   end

   assign item.start = start;
   assign item.cls   = cls;
   assign item.digit = digit;

endmodule

// ----- rtl/sitp_queue.sv -----
// Two-entry queue of classified characters between the front and back parts.
// Depends on sitp_pkg.
module sitp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sitp_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output sitp_pkg::item_type pop_item
);

   sitp_pkg::item_type                    entry_ff [sitp_pkg::QUEUE_DEPTH];
   logic [sitp_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sitp_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sitp_pkg::QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == sitp_pkg::QUEUE_COUNT_BITS'(sitp_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sitp_pkg::QUEUE_COUNT_BITS'(sitp_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue popped while empty");
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      push && pop |=> $stable(count_ff))
      else $error("queue count moved on push with pop");
`endif

endmodule

// ----- rtl/sitp_back.sv -----
// Back part of the signed integer text parser: parse state, accumulator and
// the result register. Depends on sitp_pkg.
module sitp_back #(
   parameter int WORD_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  sitp_pkg::item_type              q_item,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sitp_pkg::VALUE_BITS-1:0] rsp_value,
   output logic                            rsp_found
);

   localparam logic [2:0] PH_DONE = 3'd0;
   localparam logic [2:0] PH_LEAD = 3'd1;
   localparam logic [2:0] PH_SIGN = 3'd2;
   localparam logic [2:0] PH_ZERO = 3'd3;
   localparam logic [2:0] PH_HEX0 = 3'd4;
   localparam logic [2:0] PH_HEX  = 3'd5;
   localparam logic [2:0] PH_DEC  = 3'd6;

   logic [2:0]                      phase_ff, phase_in;
   logic [WORD_BITS-1:0]            acc_ff, acc_in;
   logic                            neg_ff, neg_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sitp_pkg::VALUE_BITS-1:0] rsp_value_ff;
   logic                            rsp_found_ff;

   logic [2:0]                      ph;
   logic [WORD_BITS-1:0]            acc;
   logic                            neg;
   logic [WORD_BITS-1:0]            digit_ext;
   logic [WORD_BITS-1:0]            acc_dec;
   logic [WORD_BITS-1:0]            acc_hex;
   logic                            emit;
   logic                            found;
   logic                            is_digit;
   logic                            out_free;
   logic [WORD_BITS-1:0]            mag;
   logic [WORD_BITS-1:0]            word_v;
   logic [sitp_pkg::VALUE_BITS-1:0] value_ext;

   always_comb begin
      ph        = q_item.start ? PH_LEAD : phase_ff;
      acc       = q_item.start ? '0 : acc_ff;
      neg       = q_item.start ? 1'b0 : neg_ff;
      digit_ext = WORD_BITS'(q_item.digit);
      acc_dec   = (acc << 3) + (acc << 1) + digit_ext;
      acc_hex   = (acc << 4) | digit_ext;
      is_digit  = (q_item.cls == sitp_pkg::CLS_ZERO) || (q_item.cls == sitp_pkg::CLS_DEC);
      phase_in  = ph;
      acc_in    = acc;
      neg_in    = neg;
      emit      = 1'b0;
      found     = 1'b0;
      unique case (ph)
         PH_LEAD, PH_SIGN: begin
            if (ph == PH_LEAD && q_item.cls == sitp_pkg::CLS_BLANK) begin
               phase_in = PH_LEAD;
            end else if (ph == PH_LEAD && q_item.cls == sitp_pkg::CLS_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGN;
            end else if (ph == PH_LEAD && q_item.cls == sitp_pkg::CLS_PLUS) begin
               phase_in = PH_SIGN;
            end else if (is_digit) begin
               acc_in   = digit_ext;
               phase_in = (q_item.cls == sitp_pkg::CLS_ZERO) ? PH_ZERO : PH_DEC;
            end else begin
               emit = 1'b1;
            end
         end
         PH_ZERO: begin
            if (q_item.cls == sitp_pkg::CLS_LOWX) begin
               phase_in = PH_HEX0;
            end else if (is_digit) begin
               acc_in   = digit_ext;
               phase_in = PH_DEC;
            end else begin
               emit  = 1'b1;
               found = 1'b1;
            end
         end
         PH_HEX0, PH_HEX: begin
            if (is_digit || q_item.cls == sitp_pkg::CLS_HEXL) begin
               acc_in   = acc_hex;
               phase_in = PH_HEX;
            end else begin
               emit  = 1'b1;
               found = 1'b1;
            end
         end
         PH_DEC: begin
            if (is_digit) begin
               acc_in = acc_dec;
            end else begin
               emit  = 1'b1;
               found = 1'b1;
            end
         end
         default: begin
            phase_in = ph;
         end
      endcase
      if (emit) begin
         phase_in = PH_DONE;
      end
   end

   always_comb begin
      mag    = found ? acc : '0;
      word_v = (found && neg) ? (~mag + 1'b1) : mag;
   end

   generate
      if (WORD_BITS >= sitp_pkg::VALUE_BITS) begin : g_trunc
         assign value_ext = word_v[sitp_pkg::VALUE_BITS-1:0];
      end else begin : g_sext
         assign value_ext = {{(sitp_pkg::VALUE_BITS-WORD_BITS){word_v[WORD_BITS-1]}}, word_v};
      end
   endgenerate

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = q_valid && (!emit || out_free);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (q_pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_value_ff <= value_ext;
         rsp_found_ff <= found;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_found = rsp_found_ff;

`ifndef NO_ASSERTIONS
   a_done_after_result: assert property (@(posedge clock) disable iff (reset)
      q_pop && emit |=> phase_ff == PH_DONE)
      else $error("parser not done after result");
   a_no_digits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_value_ff == '0)
      else $error("nonzero value without digits");
   a_start_leaves_done: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_item.start && !emit |=> phase_ff != PH_DONE)
      else $error("start flag did not begin a parse");
`endif

endmodule

// ----- rtl/signed_integer_text_parser_top.sv -----
// Top level of the signed integer text parser (atoi with 0x hexadecimal).
// Depends on sitp_pkg, sitp_front, sitp_queue and sitp_back.
//
//   channel | direction | tdata               | tuser
//   req     | in        | [7:0] ch            | [0] start_of_string
//   rsp     | out       | [31:0] value        | [0] found_digits
//
// One character per cycle sustained while rsp is not stalled; the character that
// ends the number passes a queue entry, then the result register.
// The accumulate step (shift and add over WORD_BITS) sets the clock period.
// Reset is synchronous and empties the queue and the result register.
// A stalled rsp side holds the result; up to two more characters queue behind it.
module signed_integer_text_parser_top #(
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic [0:0]  req_tuser,   // [0] start_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [0:0]  rsp_tuser    // [0] found_digits
);

   sitp_pkg::item_type front_item;
   sitp_pkg::item_type q_item;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   logic               push;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   sitp_front u_front (
      .ch    (req_tdata),
      .start (req_tuser[0]),
      .item  (front_item)
   );

   sitp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (q_item)
   );

   sitp_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_tdata),
      .rsp_found (rsp_tuser[0])
   );

endmodule

// ----- test/signed_integer_text_parser_top_test.sv -----
// Testbench for signed_integer_text_parser_top: streams character strings and checks
// every parsed value against a scoreboard that runs its own parser state machine.
// Depends on sitp_pkg and the top level of the parser.
`timescale 1ns / 1ps

module signed_integer_text_parser_top_test;

   localparam logic [sitp_pkg::CHAR_BITS-1:0] CH_NUL     = 8'h00;
   localparam logic [sitp_pkg::CHAR_BITS-1:0] CH_UPPER_X = 8'h58;
   localparam int RANDOM_ITEMS = 950;
   localparam int IDLE_PCT     = 26;
   localparam int DRAIN_CYCLES = 10;

   typedef enum logic [2:0] {
      PARSE_DONE,
      PARSE_LEAD,
      PARSE_SIGN,
      PARSE_ZERO,
      PARSE_HEX_PREFIX,
      PARSE_HEX,
      PARSE_DEC
   } parse_phase_type;

   typedef struct packed {
      logic [sitp_pkg::VALUE_BITS-1:0] value;
      logic                            found;
   } parse_result_type;

   class parse_scoreboard_type;
      parse_phase_type                 phase;
      logic [sitp_pkg::VALUE_BITS-1:0] magnitude;
      bit                              negative;
      parse_result_type                expected_q[$];
      int unsigned                     errors;

      function new();
         phase     = PARSE_DONE;
         magnitude = '0;
         negative  = 0;
         errors    = 0;
      endfunction

      function bit is_dec(logic [sitp_pkg::CHAR_BITS-1:0] ch);
         return ch >= sitp_pkg::CH_ZERO && ch <= sitp_pkg::CH_NINE;
      endfunction

      function bit is_blank(logic [sitp_pkg::CHAR_BITS-1:0] ch);
         return ch == sitp_pkg::CH_SPACE ||
                (ch >= sitp_pkg::CH_TAB && ch <= sitp_pkg::CH_CR);
      endfunction

      // 16 marks a character that is no hex digit
      function logic [4:0] hex_value(logic [sitp_pkg::CHAR_BITS-1:0] ch);
         if (is_dec(ch)) return 5'(ch - sitp_pkg::CH_ZERO);
         if (ch >= sitp_pkg::CH_LOWER_A && ch <= sitp_pkg::CH_LOWER_F)
            return 5'(ch - sitp_pkg::CH_LOWER_A + 10);
         if (ch >= sitp_pkg::CH_UPPER_A && ch <= sitp_pkg::CH_UPPER_F)
            return 5'(ch - sitp_pkg::CH_UPPER_A + 10);
         return 5'd16;
      endfunction

      function void take_first_digit(logic [sitp_pkg::CHAR_BITS-1:0] ch);
         magnitude = sitp_pkg::VALUE_BITS'(ch - sitp_pkg::CH_ZERO);
         phase     = (ch == sitp_pkg::CH_ZERO) ? PARSE_ZERO : PARSE_DEC;
      endfunction

      function void close_number(bit found);
         parse_result_type res;
         res.found = found;
         res.value = !found ? '0 : (negative ? -magnitude : magnitude);
         expected_q.push_back(res);
         phase = PARSE_DONE;
      endfunction

      function void note_input(logic [sitp_pkg::CHAR_BITS-1:0] ch, logic sos);
         logic [4:0] hex;
         if (sos) begin
            phase     = PARSE_LEAD;
            magnitude = '0;
            negative  = 0;
         end
         hex = hex_value(ch);
         case (phase)
            PARSE_LEAD: begin
               if (is_blank(ch)) begin
               end else if (ch == sitp_pkg::CH_MINUS) begin
                  negative = 1;
                  phase    = PARSE_SIGN;
               end else if (ch == sitp_pkg::CH_PLUS) begin
                  phase = PARSE_SIGN;
               end else if (is_dec(ch)) begin
                  take_first_digit(ch);
               end else begin
                  close_number(0);
               end
            end
            PARSE_SIGN: begin
               if (is_dec(ch)) take_first_digit(ch);
               else close_number(0);
            end
            PARSE_ZERO: begin
               if (ch == sitp_pkg::CH_LOWER_X) begin
                  phase = PARSE_HEX_PREFIX;
               end else if (is_dec(ch)) begin
                  magnitude = sitp_pkg::VALUE_BITS'(ch - sitp_pkg::CH_ZERO);
                  phase     = PARSE_DEC;
               end else begin
                  close_number(1);
               end
            end
            PARSE_HEX_PREFIX, PARSE_HEX: begin
               if (hex < 16) begin
                  magnitude = magnitude * 16 + sitp_pkg::VALUE_BITS'(hex);
                  phase     = PARSE_HEX;
               end else begin
                  close_number(1);
               end
            end
            PARSE_DEC: begin
               if (is_dec(ch))
                  magnitude = magnitude * 10 + sitp_pkg::VALUE_BITS'(ch - sitp_pkg::CH_ZERO);
               else close_number(1);
            end
            default: begin
            end
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("%0t: mismatch: %s", $realtime, msg);
      endtask

      task check_result(logic [sitp_pkg::VALUE_BITS-1:0] value, logic found);
         parse_result_type exp;
         if (expected_q.size() == 0) begin
            report($sformatf("result value %0d found %0b with nothing pending",
                             $signed(value), found));
         end else begin
            exp = expected_q.pop_front();
            if (value !== exp.value)
               report($sformatf("value %0d, expected %0d", $signed(value),
                                $signed(exp.value)));
            if (found !== exp.found)
               report($sformatf("found_digits %0b, expected %0b", found, exp.found));
         end
      endtask

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   parse_scoreboard_type board;
   int                   sent_items;
   int                   req_idle_pct;
   int                   rsp_idle_pct;
   logic [7:0]           text_q[$];

   signed_integer_text_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser[0]);
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_char(input logic [7:0] ch, input logic sos);
      if (sent_items >= 350 && sent_items < 520) begin
         req_idle_pct = 0;
         rsp_idle_pct = 0;
      end else begin
         req_idle_pct = IDLE_PCT;
         rsp_idle_pct = IDLE_PCT;
      end
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid   <= 1;
      req_tdata    <= ch;
      req_tuser[0] <= sos;
      do @(posedge clock); while (!req_tready);
      board.note_input(ch, sos);
      sent_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
   endtask

   task automatic send_queue();
      foreach (text_q[i]) send_char(text_q[i], i == 0);
   endtask

   function automatic logic [7:0] pick_blank();
      int k;
      k = $urandom_range(5);
      return (k == 5) ? sitp_pkg::CH_SPACE : sitp_pkg::CH_TAB + 8'(k);
   endfunction

   function automatic logic [7:0] pick_hex_digit();
      int v;
      v = $urandom_range(15);
      if (v < 10) return sitp_pkg::CH_ZERO + 8'(v);
      return ($urandom_range(1) ? sitp_pkg::CH_UPPER_A : sitp_pkg::CH_LOWER_A) + 8'(v - 10);
   endfunction

   function automatic logic [7:0] pick_terminator();
      case ($urandom_range(4))
         0: return CH_NUL;
         1: return sitp_pkg::CH_SPACE;
         2: return 8'h2C;
         3: return 8'h80 | 8'($urandom_range(127));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void build_number();
      int len;
      text_q.delete();
      repeat ($urandom_range(3)) text_q.push_back(pick_blank());
      case ($urandom_range(2))
         1: text_q.push_back(sitp_pkg::CH_PLUS);
         2: text_q.push_back(sitp_pkg::CH_MINUS);
         default: begin
         end
      endcase
      len = ($urandom_range(4) == 0) ? $urandom_range(12) : $urandom_range(4);
      case ($urandom_range(5))
         0, 1: begin
            text_q.push_back(sitp_pkg::CH_ZERO);
            text_q.push_back($urandom_range(9) == 0 ? CH_UPPER_X : sitp_pkg::CH_LOWER_X);
            repeat (len > 10 ? 10 : len) text_q.push_back(pick_hex_digit());
         end
         2: begin
            text_q.push_back(sitp_pkg::CH_ZERO);
            repeat (len) text_q.push_back(sitp_pkg::CH_ZERO + 8'($urandom_range(9)));
         end
         default: begin
            text_q.push_back(sitp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
            repeat (len) text_q.push_back(sitp_pkg::CH_ZERO + 8'($urandom_range(9)));
         end
      endcase
      // drop the terminator now and then so that the next start cuts in
      if ($urandom_range(9) != 0) text_q.push_back(pick_terminator());
   endfunction

   function automatic void build_noise();
      text_q.delete();
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
   endfunction

   initial begin
      board        = new();
      sent_items   = 0;
      req_idle_pct = IDLE_PCT;
      rsp_idle_pct = IDLE_PCT;
      reset        = 1;
      req_tvalid   = 0;
      req_tdata    = '0;
      req_tuser    = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_text("-0x1F");
      send_char(CH_NUL, 0);
      send_char(sitp_pkg::CH_SPACE, 1);
      for (int k = 0; k <= sitp_pkg::CH_CR - sitp_pkg::CH_TAB; k++)
         send_char(sitp_pkg::CH_TAB + 8'(k), 0);
      send_text("+7,");
      send_char(sitp_pkg::CH_ZERO, 1);
      send_char(CH_UPPER_X, 0);
      send_text("0xg");
      send_text("- ");
      send_text("a");
      send_text("12");
      send_text("9");
      send_char(CH_NUL, 0);
      send_char("z", 0);
      send_char(CH_NUL, 1);
      send_char("5", 1);
      send_char(8'hFF, 0);
      send_text("08");
      send_char(CH_NUL, 0);

      while (sent_items < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 85) build_number();
         else build_noise();
         send_queue();
         if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)), 0);
      end
      req_tvalid <= 0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- signed_integer_text_parser_top.f -----
rtl/sitp_pkg.sv
rtl/sitp_front.sv
rtl/sitp_queue.sv
rtl/sitp_back.sv
rtl/signed_integer_text_parser_top.sv
test/signed_integer_text_parser_top_test.sv
